### design/jsu_pkg.sv
// jsu_pkg: shared types and constants for the json string unescaper.
// Result kinds, character codes, the utf-8 encoder and the hex digit decoder.
// No dependencies.
package jsu_pkg;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_END     = 3'd1,
		KIND_BAD_ESC = 3'd2,
		KIND_BAD_UNI = 3'd3,
		KIND_UNTERM  = 3'd4
	} kind_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LB = 8'h62;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_LN = 8'h6E;
	localparam logic [7:0] CH_LR = 8'h72;
	localparam logic [7:0] CH_LT = 8'h74;
	localparam logic [7:0] CH_LU = 8'h75;

	localparam logic [20:0] CP_MAX1 = 21'h00007F;
	localparam logic [20:0] CP_MAX2 = 21'h0007FF;
	localparam logic [20:0] CP_MAX3 = 21'h00FFFF;
	localparam logic [15:0] HIGH_LO = 16'hD800;
	localparam logic [15:0] HIGH_HI = 16'hDBFF;
	localparam logic [15:0] LOW_LO = 16'hDC00;
	localparam logic [15:0] LOW_HI = 16'hDFFF;
	localparam logic [5:0] SURR_TOP = 6'b110110;
	localparam logic [10:0] PLANE_OFS = 11'd64;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic utf8_t encode(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		if (cp <= CP_MAX1) begin
			r.bytes[0] = cp[7:0];
			r.n = 3'd1;
		end else if (cp <= CP_MAX2) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.n = 3'd2;
		end else if (cp <= CP_MAX3) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.n = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.n = 3'd4;
		end
		return r;
	endfunction

	function automatic hex_t hex_digit(input logic [7:0] b);
		hex_t r;
		r.ok = 1'b1;
		r.val = '0;
		case (b) inside
			[8'h30:8'h39]: r.val = b[3:0];
			[8'h41:8'h46], [8'h61:8'h66]: r.val = 4'(b[3:0] + 4'd9);
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### design/json_string_unescape_utf8.sv
// json_string_unescape_utf8: decodes a json string body into utf-8 bytes.
// The input channel (in_valid/in_stall) takes one body byte per transaction,
// starting after the opening quote; end_of_text marks that the text ran out.
// The output channel (out_valid/out_stall) gives one result per transaction:
// a data byte, a string end or an error kind, with last set on the final
// result caused by an input byte. Each input yields zero to four results.
// The first result is registered and appears in the cycle after input acceptance.
// Throughput is one input per cycle while each input yields at most one
// result and the receiver does not stall; an input with more results holds
// the input until the single four-entry result buffer has drained them.
// The next input is taken in the same cycle the last buffered result leaves.
// When the receiver stalls the buffer holds, and in_stall stays high while
// any buffered result waits. Reset empties the buffer and returns the decoder
// to normal character mode with no pending escape or surrogate.
// Depends on jsu_pkg.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] out_kind,
	output logic [7:0] out_byte,
	output logic       last
);

	typedef enum logic [2:0] {
		M_NORMAL,
		M_ESC,
		M_HEX1,
		M_HIGH,
		M_HIGH_BS,
		M_HEX2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [15:0] hex_q, hex_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  high_q, high_d;

	jsu_pkg::kind_t res_kind_q [4];
	logic [7:0]     res_byte_q [4];
	logic [1:0]     last_idx_q;
	logic [1:0]     idx_q;
	logic           valid_q;

	// decode results before assembly
	logic           emit_hi;
	logic           tail_one;
	jsu_pkg::kind_t tail_kind;
	logic [7:0]     tail_byte;
	logic           tail_enc;
	logic [20:0]    tail_cp;

	jsu_pkg::utf8_t hi_enc, t_enc;
	jsu_pkg::hex_t  dig;
	logic [15:0]    nh;

	jsu_pkg::kind_t new_kind [4];
	logic [7:0]     new_byte [4];
	logic [2:0]     new_n;

	logic out_fire, drain_last, in_fire;

	assign out_fire = valid_q && !out_stall;
	assign drain_last = out_fire && (idx_q == last_idx_q);
	assign in_stall = valid_q && !drain_last;
	assign in_fire = in_valid && !in_stall;

	assign out_valid = valid_q;
	assign out_kind = res_kind_q[idx_q];
	assign out_byte = res_byte_q[idx_q];
	assign last = (idx_q == last_idx_q);

	assign dig = jsu_pkg::hex_digit(in_byte);
	assign nh = {hex_q[11:0], dig.val};

	always_comb begin
		mode_d = mode_q;
		hex_d = hex_q;
		cnt_d = cnt_q;
		high_d = high_q;
		emit_hi = 1'b0;
		tail_one = 1'b0;
		tail_kind = jsu_pkg::KIND_DATA;
		tail_byte = '0;
		tail_enc = 1'b0;
		tail_cp = '0;

		if (end_of_text) begin
			tail_one = 1'b1;
			case (mode_q)
				M_ESC: tail_kind = jsu_pkg::KIND_BAD_ESC;
				M_HEX1, M_HEX2: tail_kind = jsu_pkg::KIND_BAD_UNI;
				M_HIGH: begin
					emit_hi = 1'b1;
					tail_kind = jsu_pkg::KIND_UNTERM;
				end
				M_HIGH_BS: begin
					emit_hi = 1'b1;
					tail_kind = jsu_pkg::KIND_BAD_ESC;
				end
				default: tail_kind = jsu_pkg::KIND_UNTERM;
			endcase
			mode_d = M_NORMAL;
			hex_d = '0;
			cnt_d = '0;
			high_d = '0;
		end else begin
			case (mode_q)
				M_ESC, M_HIGH_BS: begin
					if (mode_q == M_HIGH_BS && in_byte == jsu_pkg::CH_LU) begin
						mode_d = M_HEX2;
						hex_d = '0;
						cnt_d = '0;
					end else begin
						if (mode_q == M_HIGH_BS) begin
							emit_hi = 1'b1;
							high_d = '0;
						end
						mode_d = M_NORMAL;
						tail_one = 1'b1;
						case (in_byte)
							jsu_pkg::CH_QUOTE: tail_byte = 8'h22;
							jsu_pkg::CH_BSLASH: tail_byte = 8'h5C;
							jsu_pkg::CH_SLASH: tail_byte = 8'h2F;
							jsu_pkg::CH_LB: tail_byte = 8'h08;
							jsu_pkg::CH_LF: tail_byte = 8'h0C;
							jsu_pkg::CH_LN: tail_byte = 8'h0A;
							jsu_pkg::CH_LR: tail_byte = 8'h0D;
							jsu_pkg::CH_LT: tail_byte = 8'h09;
							jsu_pkg::CH_LU: begin
								tail_one = 1'b0;
								mode_d = M_HEX1;
								hex_d = '0;
								cnt_d = '0;
							end
							default: begin
								tail_kind = jsu_pkg::KIND_BAD_ESC;
								hex_d = '0;
								cnt_d = '0;
								high_d = '0;
							end
						endcase
					end
				end
				M_HEX1, M_HEX2: begin
					if (!dig.ok) begin
						tail_one = 1'b1;
						tail_kind = jsu_pkg::KIND_BAD_UNI;
						mode_d = M_NORMAL;
						hex_d = '0;
						cnt_d = '0;
						high_d = '0;
					end else if (cnt_q != 2'd3) begin
						hex_d = nh;
						cnt_d = 2'(cnt_q + 2'd1);
					end else begin
						hex_d = '0;
						cnt_d = '0;
						mode_d = M_NORMAL;
						if (mode_q == M_HEX1) begin
							if (nh >= jsu_pkg::HIGH_LO && nh <= jsu_pkg::HIGH_HI) begin
								high_d = nh[9:0];
								mode_d = M_HIGH;
							end else begin
								tail_enc = 1'b1;
								tail_cp = {5'd0, nh};
							end
						end else begin
							tail_enc = 1'b1;
							high_d = '0;
							// paired surrogates: 0x10000 + (high << 10) + low
							if (nh >= jsu_pkg::LOW_LO && nh <= jsu_pkg::LOW_HI)
								tail_cp = {11'({1'b0, high_q} + jsu_pkg::PLANE_OFS), nh[9:0]};
							else
								tail_cp = {5'd0, jsu_pkg::SURR_TOP, high_q};
						end
					end
				end
				default: begin
					// normal mode, also after a pending high surrogate
					if (mode_q == M_HIGH && in_byte == jsu_pkg::CH_BSLASH) begin
						mode_d = M_HIGH_BS;
					end else begin
						if (mode_q == M_HIGH) begin
							emit_hi = 1'b1;
							high_d = '0;
						end
						mode_d = M_NORMAL;
						if (in_byte == jsu_pkg::CH_QUOTE) begin
							tail_one = 1'b1;
							tail_kind = jsu_pkg::KIND_END;
							hex_d = '0;
							cnt_d = '0;
							high_d = '0;
						end else if (in_byte == jsu_pkg::CH_BSLASH) begin
							mode_d = M_ESC;
						end else begin
							tail_one = 1'b1;
							tail_byte = in_byte;
						end
					end
				end
			endcase
		end
	end

	assign hi_enc = jsu_pkg::encode({5'd0, jsu_pkg::SURR_TOP, high_q});
	assign t_enc = jsu_pkg::encode(tail_cp);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			new_kind[i] = jsu_pkg::KIND_DATA;
			new_byte[i] = '0;
		end
		new_n = '0;
		if (emit_hi) begin
			new_byte[0] = hi_enc.bytes[0];
			new_byte[1] = hi_enc.bytes[1];
			new_byte[2] = hi_enc.bytes[2];
			new_kind[3] = tail_kind;
			new_byte[3] = (tail_kind == jsu_pkg::KIND_DATA) ? tail_byte : 8'd0;
			new_n = tail_one ? 3'd4 : 3'd3;
		end else if (tail_enc) begin
			for (int i = 0; i < 4; i++)
				new_byte[i] = t_enc.bytes[i];
			new_n = t_enc.n;
		end else if (tail_one) begin
			new_kind[0] = tail_kind;
			new_byte[0] = (tail_kind == jsu_pkg::KIND_DATA) ? tail_byte : 8'd0;
			new_n = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			hex_q <= '0;
			cnt_q <= '0;
			high_q <= '0;
			valid_q <= 1'b0;
			idx_q <= '0;
			last_idx_q <= '0;
		end else if (in_fire) begin
			mode_q <= mode_d;
			hex_q <= hex_d;
			cnt_q <= cnt_d;
			high_q <= high_d;
			idx_q <= '0;
			valid_q <= (new_n != 3'd0);
			last_idx_q <= 2'(new_n - 3'd1);
		end else if (out_fire) begin
			if (drain_last)
				valid_q <= 1'b0;
			else
				idx_q <= 2'(idx_q + 2'd1);
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (in_fire && new_n != 3'd0) begin
			for (int i = 0; i < 4; i++) begin
				res_kind_q[i] <= new_kind[i];
				res_byte_q[i] <= new_byte[i];
			end
		end
	end

endmodule

### bench/json_string_unescape_utf8_tb.sv
// json_string_unescape_utf8_tb: self-checking bench for the json string unescaper.
// Drives string body bytes, predicts the utf-8 result stream, checks each result.
// Depends on jsu_pkg and json_string_unescape_utf8.
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;

	localparam int ITEM_TOTAL = 280;
	localparam int QUIET_UNTIL = 120;
	localparam int STUCK_LIMIT = 2000;

	typedef enum logic [3:0] {
		DEC_NORMAL  = 4'd0,
		DEC_ESC     = 4'd1,
		DEC_HEX1    = 4'd2,
		DEC_HIGH    = 4'd3,
		DEC_HIGH_BS = 4'd4,
		DEC_HEX2    = 4'd5
	} dec_mode_t;

	typedef struct {
		jsu_pkg::kind_t kind;
		logic [7:0]     data;
		logic           last;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] out_kind;
	logic [7:0] out_byte;
	logic       last;

	// decoder copy kept by the bench
	dec_mode_t   dec_mode = DEC_NORMAL;
	logic [15:0] hex_acc = '0;
	logic [1:0]  hex_count = '0;
	logic [9:0]  high_bits = '0;

	result_t expected_q[$];
	result_t item_results[$];
	result_t oldest;
	int      failures = 0;
	int      n_sent = 0;
	int      stuck_cycles = 0;
	bit      idle_on = 1'b1;

	json_string_unescape_utf8 i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int hex_val(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic void push_result(jsu_pkg::kind_t k, logic [7:0] b);
		result_t r;
		if (item_results.size() >= 4) return;
		r.kind = k;
		r.data = (k == jsu_pkg::KIND_DATA) ? b : 8'h00;
		r.last = 1'b0;
		item_results = {item_results, r};
	endfunction

	function automatic void push_code_point(logic [20:0] cp);
		if (cp < 21'h80) begin
			push_result(jsu_pkg::KIND_DATA, cp[7:0]);
		end else if (cp < 21'h800) begin
			push_result(jsu_pkg::KIND_DATA, 8'hC0 | 8'(cp >> 6));
			push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F));
		end else if (cp < 21'h10000) begin
			push_result(jsu_pkg::KIND_DATA, 8'hE0 | 8'(cp >> 12));
			push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F));
			push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F));
		end else begin
			push_result(jsu_pkg::KIND_DATA, 8'hF0 | 8'((cp >> 18) & 21'h07));
			push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 12) & 21'h3F));
			push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F));
			push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F));
		end
	endfunction

	function automatic void end_string(jsu_pkg::kind_t k);
		push_result(k, 8'h00);
		dec_mode = DEC_NORMAL;
		hex_acc = '0;
		hex_count = '0;
		high_bits = '0;
	endfunction

	function automatic void flush_high();
		push_code_point(21'(jsu_pkg::HIGH_LO) + 21'(high_bits));
		high_bits = '0;
	endfunction

	function automatic void plain_char(logic [7:0] b);
		if (b == jsu_pkg::CH_QUOTE) end_string(jsu_pkg::KIND_END);
		else if (b == jsu_pkg::CH_BSLASH) dec_mode = DEC_ESC;
		else push_result(jsu_pkg::KIND_DATA, b);
	endfunction

	function automatic void escaped_char(logic [7:0] b);
		logic [7:0] v;
		dec_mode = DEC_NORMAL;
		case (b)
			jsu_pkg::CH_QUOTE: v = 8'h22;
			jsu_pkg::CH_BSLASH: v = 8'h5C;
			jsu_pkg::CH_SLASH: v = 8'h2F;
			jsu_pkg::CH_LB: v = 8'h08;
			jsu_pkg::CH_LF: v = 8'h0C;
			jsu_pkg::CH_LN: v = 8'h0A;
			jsu_pkg::CH_LR: v = 8'h0D;
			jsu_pkg::CH_LT: v = 8'h09;
			jsu_pkg::CH_LU: begin
				dec_mode = DEC_HEX1;
				hex_acc = '0;
				hex_count = '0;
				return;
			end
			default: begin
				end_string(jsu_pkg::KIND_BAD_ESC);
				return;
			end
		endcase
		push_result(jsu_pkg::KIND_DATA, v);
	endfunction

	function automatic void hex_char_in(logic [7:0] b, bit second);
		int          d;
		logic [15:0] v;
		logic [20:0] cp;
		d = hex_val(b);
		if (d < 0) begin
			end_string(jsu_pkg::KIND_BAD_UNI);
			return;
		end
		hex_acc = {hex_acc[11:0], 4'(d)};
		if (hex_count < 2'd3) begin
			hex_count++;
			return;
		end
		v = hex_acc;
		hex_acc = '0;
		hex_count = '0;
		if (!second) begin
			if (v >= jsu_pkg::HIGH_LO && v <= jsu_pkg::HIGH_HI) begin
				high_bits = v[9:0];
				dec_mode = DEC_HIGH;
			end else begin
				dec_mode = DEC_NORMAL;
				push_code_point(21'(v));
			end
			return;
		end
		// a second value that is not a low half is dropped
		if (v >= jsu_pkg::LOW_LO && v <= jsu_pkg::LOW_HI)
			cp = 21'h10000 + 21'({high_bits, v[9:0]});
		else
			cp = 21'(jsu_pkg::HIGH_LO) + 21'(high_bits);
		high_bits = '0;
		dec_mode = DEC_NORMAL;
		push_code_point(cp);
	endfunction

	function automatic void predict_utf8(logic [7:0] b, logic eot);
		item_results.delete();
		if (eot) begin
			case (dec_mode)
				DEC_ESC: end_string(jsu_pkg::KIND_BAD_ESC);
				DEC_HEX1, DEC_HEX2: end_string(jsu_pkg::KIND_BAD_UNI);
				DEC_HIGH: begin
					flush_high();
					end_string(jsu_pkg::KIND_UNTERM);
				end
				DEC_HIGH_BS: begin
					flush_high();
					end_string(jsu_pkg::KIND_BAD_ESC);
				end
				default: end_string(jsu_pkg::KIND_UNTERM);
			endcase
		end else begin
			case (dec_mode)
				DEC_ESC: escaped_char(b);
				DEC_HEX1: hex_char_in(b, 1'b0);
				DEC_HEX2: hex_char_in(b, 1'b1);
				DEC_HIGH: begin
					if (b == jsu_pkg::CH_BSLASH) begin
						dec_mode = DEC_HIGH_BS;
					end else begin
						flush_high();
						dec_mode = DEC_NORMAL;
						plain_char(b);
					end
				end
				DEC_HIGH_BS: begin
					if (b == jsu_pkg::CH_LU) begin
						dec_mode = DEC_HEX2;
						hex_acc = '0;
						hex_count = '0;
					end else begin
						flush_high();
						escaped_char(b);
					end
				end
				default: begin
					dec_mode = DEC_NORMAL;
					plain_char(b);
				end
			endcase
		end
		if (item_results.size() > 0) item_results[$].last = 1'b1;
		expected_q = {expected_q, item_results};
	endfunction

	task automatic send_item(logic [7:0] b, logic eot);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 25) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_byte = b;
		end_of_text = eot;
		do @(posedge clk); while (in_stall);
		predict_utf8(b, eot);
		n_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	task automatic send_hex4(logic [15:0] v);
		for (int i = 3; i >= 0; i--)
			send_item(hex_char(v[4*i +: 4], 1'($urandom_range(1))), 1'b0);
	endtask

	task automatic send_high_half();
		send_text("\\u");
		send_hex4(16'($urandom_range(jsu_pkg::HIGH_HI, jsu_pkg::HIGH_LO)));
	endtask

	task automatic send_random_token();
		string      esc_set;
		logic [7:0] b;
		int         pick;
		int         k;
		esc_set = "\"\\/bfnrt";
		pick = $urandom_range(99);
		if (pick < 30) begin
			k = $urandom_range(4, 1);
			repeat (k) send_item(8'($urandom_range(255)), 1'b0);
		end else if (pick < 45) begin
			send_item(jsu_pkg::CH_BSLASH, 1'b0);
			send_item(esc_set[$urandom_range(7)], 1'b0);
		end else if (pick < 60) begin
			send_text("\\u");
			case ($urandom_range(3))
				0: send_hex4(16'($urandom_range(16'h7F)));
				1: send_hex4(16'($urandom_range(16'h7FF, 16'h80)));
				2: send_hex4(16'($urandom_range(16'hFFFF, 16'h800)));
				default: send_hex4(16'($urandom_range(jsu_pkg::LOW_HI, jsu_pkg::LOW_LO)));
			endcase
		end else if (pick < 70) begin
			send_high_half();
			send_text("\\u");
			send_hex4(16'($urandom_range(jsu_pkg::LOW_HI, jsu_pkg::LOW_LO)));
		end else if (pick < 75) begin
			send_high_half();
			send_text("\\u");
			if ($urandom_range(1)) send_hex4(16'($urandom_range(jsu_pkg::HIGH_HI)));
			else send_hex4(16'($urandom_range(16'hFFFF, 16'hE000)));
		end else if (pick < 80) begin
			// lone high half followed by something other than a low half
			send_high_half();
			case ($urandom_range(4))
				0: send_item(8'($urandom_range(255)), 1'b0);
				1: begin
					send_item(jsu_pkg::CH_BSLASH, 1'b0);
					send_item(esc_set[$urandom_range(7)], 1'b0);
				end
				2: begin
					send_item(jsu_pkg::CH_BSLASH, 1'b0);
					send_item(8'($urandom_range(255)), 1'b0);
				end
				3: send_item(8'($urandom_range(255)), 1'b1);
				default: begin
					send_item(jsu_pkg::CH_BSLASH, 1'b0);
					send_item(8'($urandom_range(255)), 1'b1);
				end
			endcase
		end else if (pick < 85) begin
			send_item(jsu_pkg::CH_BSLASH, 1'b0);
			send_item(8'($urandom_range(255)), 1'b0);
		end else if (pick < 89) begin
			if ($urandom_range(1)) send_high_half();
			send_text("\\u");
			k = $urandom_range(3);
			repeat (k)
				send_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
			do b = 8'($urandom_range(255)); while (hex_val(b) >= 0);
			send_item(b, 1'b0);
		end else if (pick < 95) begin
			send_item(jsu_pkg::CH_QUOTE, 1'b0);
		end else begin
			case ($urandom_range(2))
				0: ;
				1: send_item(jsu_pkg::CH_BSLASH, 1'b0);
				default: begin
					send_text("\\u");
					k = $urandom_range(3);
					repeat (k) send_item(hex_char(4'($urandom_range(15)), 1'b0), 1'b0);
				end
			endcase
			send_item(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic test_raw_bytes();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(jsu_pkg::CH_QUOTE, 1'b0);
	endtask

	task automatic test_escapes();
		send_text("\\t\\q");
	endtask

	task automatic test_surrogate_pair();
		send_text("\\uD83d\\uDE00");
	endtask

	task automatic test_unterminated_high();
		send_text("\\uDBFF");
		send_item(8'hFF, 1'b1);
	endtask

	task automatic test_random_text(int upto);
		while (n_sent < upto) send_random_token();
	endtask

	task automatic test_drain_pause();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < 25);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result: out_kind %0d out_byte %0h last %0b",
					out_kind, out_byte, last);
				failures++;
			end else begin
				oldest = expected_q.pop_front();
				if (out_kind !== oldest.kind) begin
					$error("out_kind: expected %0d, got %0d", oldest.kind, out_kind);
					failures++;
				end
				if (out_byte !== oldest.data) begin
					$error("out_byte: expected %0h, got %0h", oldest.data, out_byte);
					failures++;
				end
				if (last !== oldest.last) begin
					$error("last: expected %0b, got %0b", oldest.last, last);
					failures++;
				end
			end
		end
	end

	// ends the run when no transaction moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$error("no transaction for %0d cycles", STUCK_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_raw_bytes();
		test_escapes();
		test_surrogate_pair();
		test_unterminated_high();
		idle_on = 1'b0;
		test_random_text(QUIET_UNTIL);
		idle_on = 1'b1;
		test_drain_pause();
		test_random_text(ITEM_TOTAL);

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
design/jsu_pkg.sv
design/json_string_unescape_utf8.sv
bench/json_string_unescape_utf8_tb.sv
